>>> rtl/kfpi_pkg.sv
package kfpi_pkg;
    localparam int DEF_TABLE_DEPTH = 128;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HELD  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int TIME_W = 23;
    localparam int SUM_W  = 24;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 41;

    // Controller to datapath.
    typedef struct packed {
        logic       load;       // capture the input item
        logic       wr;         // write the captured point into the table
        logic       rd;         // read table entry at the read address
        logic       rd_first;   // the read is of entry 0
        logic       step;       // evaluate the fetched segment
        logic       div_start;  // start the three dividers
        logic       fin;        // capture the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       seg_take;   // the walk goes on past the fetched segment
        logic       div_done;
    } t_stat;
endpackage

>>> rtl/kfpi_div.sv
module kfpi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kfpi_pkg::PROD_W-1:0] i_num,
    input  logic [15:0]                 i_den,
    output logic [kfpi_pkg::PROD_W-1:0] o_quo,
    output logic                        o_done
);
    import kfpi_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] r_quo, n_quo;
    logic [16:0]       r_rem, n_rem;
    logic [15:0]       r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [16:0]       w_trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_trial = {r_rem[15:0], r_quo[PROD_W-1]};
        n_quo   = {r_quo[PROD_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule

>>> rtl/kfpi_datapath.sv
module kfpi_datapath #(
    parameter int TABLE_DEPTH = kfpi_pkg::DEF_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                        i_clk,
    input  kfpi_pkg::t_cmd              i_cmd,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  logic [IDX_W-1:0]            i_rd_addr,
    input  logic                        i_wr_zero_dur,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic signed [15:0]          i_pos_z,
    input  logic [15:0]                 i_segment_time,
    input  logic [kfpi_pkg::TIME_W-1:0] i_query_time,
    input  logic                        i_res_zero,
    input  logic                        i_res_interp,
    output kfpi_pkg::t_stat             o_stat,
    output logic signed [15:0]          o_out_x,
    output logic signed [15:0]          o_out_y,
    output logic signed [15:0]          o_out_z
);
    import kfpi_pkg::*;

    logic signed [15:0] mem_x [TABLE_DEPTH];
    logic signed [15:0] mem_y [TABLE_DEPTH];
    logic signed [15:0] mem_z [TABLE_DEPTH];
    logic [15:0]        mem_d [TABLE_DEPTH];

    logic signed [15:0] r_px, r_py, r_pz;
    logic [15:0]        r_pd;
    logic [TIME_W-1:0]  r_t;
    logic signed [15:0] r_rx, r_ry, r_rz;
    logic [15:0]        r_rd_d;
    logic               r_rd_first;
    logic signed [15:0] r_lx, r_ly, r_lz;
    logic signed [15:0] r_tx, r_ty, r_tz;
    logic [15:0]        r_den;
    logic [SUM_W-1:0]   r_sum;
    logic               r_neg_x, r_neg_y, r_neg_z;
    logic [PROD_W-1:0]  w_nx, w_ny, w_nz;
    logic [PROD_W-1:0]  w_qx, w_qy, w_qz;
    logic               w_dx, w_dy, w_dz;
    logic [SUM_W-1:0]   w_next;
    logic signed [DIFF_W-1:0] w_ddx, w_ddy, w_ddz;
    logic [TIME_W-1:0]  w_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
            r_pd <= i_wr_zero_dur ? 16'd0 : i_segment_time;
            r_t  <= i_query_time;
        end
        if (i_cmd.wr) begin
            mem_x[i_wr_addr] <= r_px;
            mem_y[i_wr_addr] <= r_py;
            mem_z[i_wr_addr] <= r_pz;
            mem_d[i_wr_addr] <= r_pd;
        end
        if (i_cmd.rd) begin
            r_rx   <= mem_x[i_rd_addr];
            r_ry   <= mem_y[i_rd_addr];
            r_rz   <= mem_z[i_rd_addr];
            r_rd_d <= mem_d[i_rd_addr];
        end
        r_rd_first <= i_cmd.rd_first;
    end

    assign w_next = r_sum + SUM_W'(r_rd_d);
    assign o_stat.seg_take = w_next < SUM_W'(r_t);

    // A fetched row of entry 0 seeds the walk; later rows either advance it
    // or become the target of the current segment.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (r_rd_first) begin
                r_lx  <= r_rx;
                r_ly  <= r_ry;
                r_lz  <= r_rz;
                r_sum <= '0;
            end else if (o_stat.seg_take) begin
                r_lx  <= r_rx;
                r_ly  <= r_ry;
                r_lz  <= r_rz;
                r_sum <= w_next;
            end else begin
                r_tx  <= r_rx;
                r_ty  <= r_ry;
                r_tz  <= r_rz;
                r_den <= r_rd_d;
            end
        end
    end

    assign w_ddx = DIFF_W'(r_tx) - DIFF_W'(r_lx);
    assign w_ddy = DIFF_W'(r_ty) - DIFF_W'(r_ly);
    assign w_ddz = DIFF_W'(r_tz) - DIFF_W'(r_lz);
    assign w_num = r_t - r_sum[TIME_W-1:0];

    // Magnitude times elapsed time; the sign is restored after the divide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg_x <= w_ddx[DIFF_W-1];
            r_neg_y <= w_ddy[DIFF_W-1];
            r_neg_z <= w_ddz[DIFF_W-1];
        end
    end

    always_comb begin
        w_nx = PROD_W'(w_ddx[DIFF_W-1] ? -w_ddx : w_ddx) * PROD_W'(w_num);
        w_ny = PROD_W'(w_ddy[DIFF_W-1] ? -w_ddy : w_ddy) * PROD_W'(w_num);
        w_nz = PROD_W'(w_ddz[DIFF_W-1] ? -w_ddz : w_ddz) * PROD_W'(w_num);
    end

    kfpi_div u_div_x (.i_clk, .i_rst_n(1'b1), .i_start(i_cmd.div_start),
        .i_num(w_nx), .i_den(r_den), .o_quo(w_qx), .o_done(w_dx));
    kfpi_div u_div_y (.i_clk, .i_rst_n(1'b1), .i_start(i_cmd.div_start),
        .i_num(w_ny), .i_den(r_den), .o_quo(w_qy), .o_done(w_dy));
    kfpi_div u_div_z (.i_clk, .i_rst_n(1'b1), .i_start(i_cmd.div_start),
        .i_num(w_nz), .i_den(r_den), .o_quo(w_qz), .o_done(w_dz));

    assign o_stat.div_done = w_dx & w_dy & w_dz;

    // A segment of zero duration returns its start point.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (i_res_zero) begin
                o_out_x <= '0;
                o_out_y <= '0;
                o_out_z <= '0;
            end else if (i_res_interp && r_den != 16'd0) begin
                o_out_x <= r_lx + (r_neg_x ? -w_qx[15:0] : w_qx[15:0]);
                o_out_y <= r_ly + (r_neg_y ? -w_qy[15:0] : w_qy[15:0]);
                o_out_z <= r_lz + (r_neg_z ? -w_qz[15:0] : w_qz[15:0]);
            end else begin
                o_out_x <= r_lx;
                o_out_y <= r_ly;
                o_out_z <= r_lz;
            end
        end
    end
endmodule

>>> rtl/kfpi_ctrl.sv
module kfpi_ctrl #(
    parameter int TABLE_DEPTH = kfpi_pkg::DEF_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_op,
    output logic             o_valid,
    input  logic             i_ready,
    input  kfpi_pkg::t_stat  i_stat,
    output kfpi_pkg::t_cmd   o_cmd,
    output logic [IDX_W-1:0] o_wr_addr,
    output logic [IDX_W-1:0] o_rd_addr,
    output logic             o_wr_zero_dur,
    output logic             o_res_zero,
    output logic             o_res_interp,
    output logic [1:0]       o_status
);
    import kfpi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op;
    logic [7:0] r_count;
    logic [7:0] r_idx;
    logic       r_zero, r_interp;
    logic [1:0] r_status;
    logic       w_accept;

    assign w_accept      = i_valid && o_ready;
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_wr_zero_dur = (i_op == OP_RESTART);
    assign o_wr_addr     = (r_op == OP_RESTART) ? '0 : r_count[IDX_W-1:0];
    assign o_rd_addr     = r_idx[IDX_W-1:0];
    assign o_res_zero    = r_zero;
    assign o_res_interp  = r_interp;
    assign o_status      = r_status;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.wr       = (r_state == S_WR);
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.rd_first = (r_state == S_RD) && (r_idx == 8'd0);
        o_cmd.step     = (r_state == S_STEP);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.fin      = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_op     <= OP_RESTART;
            r_idx    <= '0;
            r_zero   <= 1'b0;
            r_interp <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_op     <= i_op;
                    r_idx    <= '0;
                    r_zero   <= 1'b1;
                    r_interp <= 1'b0;
                    r_status <= ST_OK;
                    if (i_op == OP_APPEND && r_count >= 8'(TABLE_DEPTH))
                        r_status <= ST_FULL;
                    if (i_op == OP_QUERY && r_count == 8'd0)
                        r_status <= ST_EMPTY;
                end
                S_WR: begin
                    r_count <= (r_op == OP_RESTART) ? 8'd1 : r_count + 8'd1;
                end
                S_RD: ;
                S_STEP: begin
                    r_zero <= 1'b0;
                    if (r_idx == 8'd0 || i_stat.seg_take) begin
                        r_idx <= r_idx + 8'd1;
                        if (r_idx + 8'd1 >= r_count) r_status <= ST_HELD;
                    end
                end
                S_DIV:  r_interp <= 1'b1;
                S_WAIT: ;
                S_FIN:  ;
                S_OUT:  ;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                priority if (i_op == OP_RESTART) n_state = S_WR;
                else if (i_op == OP_APPEND && r_count < 8'(TABLE_DEPTH)) n_state = S_WR;
                else if (i_op == OP_QUERY && r_count != 8'd0) n_state = S_RD;
                else n_state = S_FIN;
            end
            S_WR:   n_state = S_FIN;
            S_RD:   n_state = S_STEP;
            S_STEP: begin
                if (r_idx == 8'd0 || i_stat.seg_take)
                    n_state = (r_idx + 8'd1 >= r_count) ? S_FIN : S_RD;
                else
                    n_state = S_DIV;
            end
            S_DIV:  n_state = S_WAIT;
            S_WAIT: if (i_stat.div_done) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/keyframe_path_interpolator.sv
// Sequential: one item at a time. Restart and append write the table and then
// offer their result; a refused append, unknown op or empty query offers it directly.
// A query fetches and compares one entry at a time, from entry 0, in a read state
// and a compare state, until it reaches the last entry and offers a held result, or
// finds its segment and offers one after three 41-step bit-serial divides run together.
// The next item is accepted from the cycle after the result is taken.
// Synchronous active-low reset empties the table; table contents are not cleared.
module keyframe_path_interpolator #(
    parameter int TABLE_DEPTH = kfpi_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic signed [15:0]          i_pos_z,
    input  logic [15:0]                 i_segment_time,
    input  logic [kfpi_pkg::TIME_W-1:0] i_query_time,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_out_x,
    output logic signed [15:0]          o_out_y,
    output logic signed [15:0]          o_out_z,
    output logic [1:0]                  o_status
);
    import kfpi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_wr_addr, w_rd_addr;
    logic             w_zero_dur, w_res_zero, w_res_interp;

    kfpi_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .o_valid, .i_ready,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_wr_addr(w_wr_addr),
        .o_rd_addr(w_rd_addr), .o_wr_zero_dur(w_zero_dur),
        .o_res_zero(w_res_zero), .o_res_interp(w_res_interp), .o_status
    );

    kfpi_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_dp (
        .i_clk, .i_cmd(w_cmd), .i_wr_addr(w_wr_addr), .i_rd_addr(w_rd_addr),
        .i_wr_zero_dur(w_zero_dur), .i_pos_x, .i_pos_y, .i_pos_z,
        .i_segment_time, .i_query_time, .i_res_zero(w_res_zero),
        .i_res_interp(w_res_interp), .o_stat(w_stat), .o_out_x, .o_out_y,
        .o_out_z
    );
endmodule

>>> tb/keyframe_path_checker.sv
module keyframe_path_checker #(
    parameter int TABLE_DEPTH = kfpi_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic signed [15:0]          i_pos_z,
    input  logic [15:0]                 i_segment_time,
    input  logic [kfpi_pkg::TIME_W-1:0] i_query_time,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic signed [15:0]          o_out_x,
    input  logic signed [15:0]          o_out_y,
    input  logic signed [15:0]          o_out_z,
    input  logic [1:0]                  o_status,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results
);
    import kfpi_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [1:0]         status;
    } t_position;

    logic signed [15:0] path_x [TABLE_DEPTH];
    logic signed [15:0] path_y [TABLE_DEPTH];
    logic signed [15:0] path_z [TABLE_DEPTH];
    logic [15:0]        path_dur [TABLE_DEPTH];
    int                 key_count;
    t_position          position_queue [$];

    assign o_pending = position_queue.size();

    function automatic logic signed [15:0] blend(input logic signed [15:0] from,
                                                 input logic signed [15:0] to,
                                                 input longint num, input longint den);
        longint diff;
        diff = longint'(to) - longint'(from);
        // SystemVerilog integer division truncates toward zero.
        return 16'(longint'(from) + (diff * num) / den);
    endfunction

    function automatic t_position path_position(input logic [1:0] op,
                                                input logic signed [15:0] px,
                                                input logic signed [15:0] py,
                                                input logic signed [15:0] pz,
                                                input logic [15:0] dur,
                                                input logic [TIME_W-1:0] t);
        t_position r;
        int idx;
        longint sum;
        logic signed [15:0] lx, ly, lz;
        r = '0;
        r.status = ST_OK;
        if (op == OP_RESTART) begin
            path_x[0] = px; path_y[0] = py; path_z[0] = pz; path_dur[0] = '0;
            key_count = 1;
        end else if (op == OP_APPEND) begin
            if (key_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                path_x[key_count] = px; path_y[key_count] = py;
                path_z[key_count] = pz; path_dur[key_count] = dur;
                key_count++;
            end
        end else if (op == OP_QUERY) begin
            if (key_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                idx = 1;
                sum = 0;
                lx = path_x[0]; ly = path_y[0]; lz = path_z[0];
                while (idx < key_count && sum + path_dur[idx] < t) begin
                    sum += path_dur[idx];
                    lx = path_x[idx]; ly = path_y[idx]; lz = path_z[idx];
                    idx++;
                end
                if (idx >= key_count) begin
                    r.x = lx; r.y = ly; r.z = lz;
                    r.status = ST_HELD;
                end else if (path_dur[idx] == 0) begin
                    r.x = lx; r.y = ly; r.z = lz;
                end else begin
                    r.x = blend(lx, path_x[idx], t - sum, path_dur[idx]);
                    r.y = blend(ly, path_y[idx], t - sum, path_dur[idx]);
                    r.z = blend(lz, path_z[idx], t - sum, path_dur[idx]);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        key_count = 0;
    end

    always @(posedge i_clk) begin
        t_position want;
        if (!i_rst_n) begin
            key_count = 0;
        end else begin
            if (o_valid && i_ready) begin
                o_results++;
                if (position_queue.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = position_queue.pop_front();
                    if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                    if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                    if (o_out_z !== want.z) report_mismatch("out_z", o_out_z, want.z);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (i_valid && o_ready)
                position_queue.push_back(path_position(i_op, i_pos_x, i_pos_y, i_pos_z,
                                                       i_segment_time, i_query_time));
        end
    end
endmodule

>>> tb/keyframe_path_interpolator_tb.sv
module keyframe_path_interpolator_tb;
    import kfpi_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_op;
    logic signed [15:0] i_pos_x, i_pos_y, i_pos_z;
    logic [15:0]       i_segment_time;
    logic [TIME_W-1:0] i_query_time;
    logic              o_valid;
    logic              i_ready;
    logic signed [15:0] o_out_x, o_out_y, o_out_z;
    logic [1:0]        o_status;
    int                error_count, pending_count, result_count;
    int                cycle_count;
    int                item_count;
    bit                long_hold;
    bit                stimulus_done;

    // Time span of the path built since the last restart, for aiming queries.
    int                path_span;
    int                path_keys;

    keyframe_path_interpolator u_dut (.*);

    keyframe_path_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_segment_time, .i_query_time, .o_valid, .i_ready, .o_out_x, .o_out_y,
        .o_out_z, .o_status, .o_errors(error_count), .o_pending(pending_count),
        .o_results(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The handshake signals are looked at on the falling edge, where they hold
    // the values that the next rising edge samples.
    task automatic send_item(input logic [1:0] op, input logic signed [15:0] px,
                             input logic signed [15:0] py, input logic signed [15:0] pz,
                             input logic [15:0] dur, input logic [TIME_W-1:0] t,
                             input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_op = op; i_pos_x = px; i_pos_y = py; i_pos_z = pz;
        i_segment_time = dur; i_query_time = t;
        while (!o_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
        item_count++;
        if (op == OP_RESTART) begin
            path_span = 0; path_keys = 1;
        end else if (op == OP_APPEND && path_keys < DEF_TABLE_DEPTH) begin
            path_span += dur; path_keys++;
        end
    endtask

    task automatic send_random_point(input logic [1:0] op, input logic [15:0] dur,
                                     input logic [TIME_W-1:0] t);
        send_item(op, 16'($urandom), 16'($urandom), 16'($urandom), dur, t);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0: return TIME_W'($urandom);
            1: return TIME_W'(path_span + $urandom_range(0, 3));
            2: return TIME_W'(path_span > 0 ? path_span - 1 : 0);
            3: return '0;
            default: return TIME_W'($urandom_range(0, path_span + 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_count != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Receiver: random stall per result, one long hold-off on request.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            while (!o_valid) @(negedge i_clk);
        end
    end

    initial begin
        int keys;
        cycle_count = 0;
        item_count = 0;
        path_span = 0;
        path_keys = 0;
        long_hold = 0;
        stimulus_done = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_RESTART;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_segment_time = '0;
        i_query_time = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, append without restart, extremes, unknown op.
        send_item(OP_QUERY, 0, 0, 0, 0, '0);
        send_item(OP_QUERY, 0, 0, 0, 0, '1);
        send_item(OP_APPEND, 16'sh7FFF, -16'sh8000, 16'sh0001, 16'hFFFF, '0);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd5);
        send_item(2'd3, 16'sh1234, 16'sh1234, 16'sh1234, 16'h1234, '1);
        send_item(OP_RESTART, -16'sh8000, 16'sh7FFF, 16'sh0000, 16'hFFFF, '1);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd100);
        send_item(OP_APPEND, 16'sh7FFF, -16'sh8000, -16'sh1, 16'hFFFF, '0);
        send_item(OP_APPEND, 16'sh0010, 16'sh0020, 16'sh0030, 16'd0, '0);
        send_item(OP_APPEND, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd7, '0);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd0);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd1);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd32767);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd65535);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd65536);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd65538);
        send_item(OP_QUERY, 0, 0, 0, 0, 23'd65542);
        send_item(OP_QUERY, 0, 0, 0, 0, '1);

        // Fill the table to the top, then refused appends and queries.
        send_item(OP_RESTART, 0, 0, 0, 0, '0);
        for (int i = 1; i < DEF_TABLE_DEPTH + 2; i++)
            send_random_point(OP_APPEND, pick_duration(), '0);
        for (int i = 0; i < 12; i++) send_item(OP_QUERY, 0, 0, 0, 0, pick_time());

        // Receiver holds off while the sender keeps offering items.
        long_hold = 1;
        for (int i = 0; i < 10; i++) send_item(OP_QUERY, 0, 0, 0, 0, pick_time(), 1);
        wait_drained();

        // Random paths: a restart, a few keyframes (sometimes many) and queries along them.
        while (item_count < 1750) begin
            send_random_point(OP_RESTART, 16'($urandom), pick_time());
            keys = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140)
                                               : $urandom_range(0, 8);
            for (int k = 0; k < keys; k++) begin
                if ($urandom_range(0, 5) == 0)
                    send_item(OP_QUERY, 16'($urandom), 0, 0, 16'($urandom), pick_time());
                else
                    send_random_point(OP_APPEND, pick_duration(), TIME_W'($urandom));
            end
            repeat ($urandom_range(2, 10)) begin
                if ($urandom_range(0, 15) == 0)
                    send_random_point(2'($urandom), pick_duration(), pick_time());
                else
                    send_random_point(OP_QUERY, pick_duration(), pick_time());
            end
        end
        stimulus_done = 1;
        wait_drained();

        $display("Covered %0d items and %0d results: empty, held, full, zero-duration",
                 item_count, result_count);
        $display("and interpolated queries over paths of up to the full table depth.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/kfpi_pkg.sv
rtl/kfpi_div.sv
rtl/kfpi_datapath.sv
rtl/kfpi_ctrl.sv
rtl/keyframe_path_interpolator.sv
tb/keyframe_path_checker.sv
tb/keyframe_path_interpolator_tb.sv
